>>> rtl/rhc_pkg.sv
// Shared types and constants for the RGB to HSV pixel converter.
`timescale 1ns / 1ps

package rhc_pkg;

  localparam int unsigned ChanW        = 8;   // width of one colour channel
  localparam int unsigned QuotW        = 8;   // quotient bits, one divider stage each
  localparam int unsigned NumW         = 2 * ChanW;
  localparam int unsigned FifoDepthDef = 4;

  localparam logic [ChanW-1:0] HueGreenOff = 8'd60;
  localparam logic [ChanW-1:0] HueBlueOff  = 8'd120;
  localparam logic [ChanW-1:0] HueWrap     = 8'd180;

  // Which channel holds the maximum; red wins ties over green, green over blue
  typedef enum logic [1:0] {
    SectRed   = 2'd0,
    SectGreen = 2'd1,
    SectBlue  = 2'd2
  } sector_e;

  // Classified pixel handed from the front end to the divider back end
  typedef struct packed {
    logic [ChanW-1:0] value;    // channel maximum, saturation divisor
    logic [ChanW-1:0] delta;    // max - min, hue divisor
    logic [NumW-1:0]  sat_num;  // 255 * delta
    logic [NumW-1:0]  hue_num;  // 30 * |diff|
    logic             hue_neg;  // diff below zero
    sector_e          sector;
    logic             grey;     // max equals min
  } item_t;

endpackage

>>> rtl/rhc_front.sv
// Front end: takes pixel transfers, finds max/min, sector and division operands.
`timescale 1ns / 1ps

module rhc_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [23:0]         s_axis_tdata_i,   // blue, green, red
  output logic                item_valid_o,
  input  logic                item_ready_i,
  output rhc_pkg::item_t      item_o
);

  logic [rhc_pkg::ChanW-1:0] blue, green, red;
  logic [rhc_pkg::ChanW-1:0] mx, mn, pos_a, neg_a, mag;
  logic                      neg;
  rhc_pkg::item_t            item_d, item_q;
  logic                      valid_q;
  logic                      load;

  assign blue  = s_axis_tdata_i[7:0];
  assign green = s_axis_tdata_i[15:8];
  assign red   = s_axis_tdata_i[23:16];

  always_comb begin
    mx = red;
    if (green > mx) mx = green;
    if (blue > mx) mx = blue;
    mn = red;
    if (green < mn) mn = green;
    if (blue < mn) mn = blue;

    item_d.value = mx;
    item_d.delta = mx - mn;
    item_d.grey  = (mx == mn);

    // diff = pos_a - neg_a for the chosen sector
    if (mx == red) begin
      item_d.sector = rhc_pkg::SectRed;
      pos_a = green;
      neg_a = blue;
    end else if (mx == green) begin
      item_d.sector = rhc_pkg::SectGreen;
      pos_a = blue;
      neg_a = red;
    end else begin
      item_d.sector = rhc_pkg::SectBlue;
      pos_a = red;
      neg_a = green;
    end
    neg = (pos_a < neg_a);
    mag = neg ? (neg_a - pos_a) : (pos_a - neg_a);
    item_d.hue_neg = neg;

    // 255*d = (d << 8) - d ; 30*m = (m << 5) - (m << 1)
    item_d.sat_num = {item_d.delta, 8'd0} - {8'd0, item_d.delta};
    item_d.hue_num = {3'd0, mag, 5'd0} - {7'd0, mag, 1'b0};
  end

  assign s_axis_tready_o = !valid_q || item_ready_i;
  assign load            = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_d;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

>>> rtl/rhc_fifo.sv
// Short queue of classified pixels between front end and back end.
`timescale 1ns / 1ps

module rhc_fifo #(
  parameter int unsigned Depth = rhc_pkg::FifoDepthDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  rhc_pkg::item_t item_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output rhc_pkg::item_t item_o
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  rhc_pkg::item_t   mem_q [Depth];
  logic [AddrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AddrW'(Depth - 1)) ? '0 : wr_ptr_q + AddrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AddrW'(Depth - 1)) ? '0 : rd_ptr_q + AddrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

>>> rtl/rhc_back.sv
// Back end: pipelined restoring dividers, rounding, hue offset and output register.
`timescale 1ns / 1ps

module rhc_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           item_empty_i,
  input  rhc_pkg::item_t item_i,
  output logic           item_pop_o,
  output logic           m_axis_tvalid_o,
  input  logic           m_axis_tready_i,
  output logic [23:0]    m_axis_tdata_o   // hue, saturation, value
);

  localparam int unsigned QW = rhc_pkg::QuotW;
  localparam int unsigned CW = rhc_pkg::ChanW;

  // One quotient bit: shift the next numerator bit in, subtract if it fits
  function automatic logic [CW:0] div_step(input logic [CW-1:0] rem,
                                           input logic          nbit,
                                           input logic [CW-1:0] den);
    logic [CW:0] trial;
    logic [CW:0] diff;
    trial = {rem, nbit};
    diff  = trial - {1'b0, den};
    if (trial >= {1'b0, den}) begin
      div_step = {1'b1, diff[CW-1:0]};
    end else begin
      div_step = {1'b0, trial[CW-1:0]};
    end
  endfunction

  logic                adv;
  logic [QW-1:0]       st_valid_q, st_valid_d;
  rhc_pkg::item_t      st_item_q  [QW];
  rhc_pkg::item_t      st_item_d  [QW];
  logic [CW-1:0]       sat_rem_q  [QW];
  logic [CW-1:0]       sat_rem_d  [QW];
  logic [QW-1:0]       sat_quo_q  [QW];
  logic [QW-1:0]       sat_quo_d  [QW];
  logic [CW-1:0]       hue_rem_q  [QW];
  logic [CW-1:0]       hue_rem_d  [QW];
  logic [QW-1:0]       hue_quo_q  [QW];
  logic [QW-1:0]       hue_quo_d  [QW];

  logic                out_valid_q;
  logic [23:0]         out_data_q, out_data_d;

  // Whole back end moves together whenever the output register is free
  assign adv        = !out_valid_q || m_axis_tready_i;
  assign item_pop_o = adv && !item_empty_i;

  always_comb begin
    logic [CW-1:0]      s_rem, h_rem;
    logic [QW-1:0]      s_quo, h_quo;
    logic [CW:0]        s_res, h_res;
    rhc_pkg::item_t     it;
    for (int k = 0; k < QW; k++) begin
      if (k == 0) begin
        it                = item_i;
        st_valid_d[k]     = !item_empty_i;
        s_rem             = item_i.sat_num[rhc_pkg::NumW-1:QW];
        h_rem             = item_i.hue_num[rhc_pkg::NumW-1:QW];
        s_quo             = '0;
        h_quo             = '0;
      end else begin
        it                = st_item_q[k-1];
        st_valid_d[k]     = st_valid_q[k-1];
        s_rem             = sat_rem_q[k-1];
        h_rem             = hue_rem_q[k-1];
        s_quo             = sat_quo_q[k-1];
        h_quo             = hue_quo_q[k-1];
      end
      s_res = div_step(s_rem, it.sat_num[QW-1-k], it.value);
      h_res = div_step(h_rem, it.hue_num[QW-1-k], it.delta);
      s_quo[QW-1-k] = s_res[CW];
      h_quo[QW-1-k] = h_res[CW];
      st_item_d[k]  = it;
      sat_rem_d[k]  = s_res[CW-1:0];
      hue_rem_d[k]  = h_res[CW-1:0];
      sat_quo_d[k]  = s_quo;
      hue_quo_d[k]  = h_quo;
    end
  end

  // Round to nearest, ties to even, then place hue in its sector; grey pixels get zero hue and saturation
  always_comb begin
    rhc_pkg::item_t  it;
    logic [CW:0]     s_twice, h_twice;
    logic            s_up, h_up;
    logic [CW-1:0]   sat, hq, off, hue;
    it      = st_item_q[QW-1];
    s_twice = {sat_rem_q[QW-1], 1'b0};
    h_twice = {hue_rem_q[QW-1], 1'b0};
    s_up    = (s_twice > {1'b0, it.value}) ||
              ((s_twice == {1'b0, it.value}) && sat_quo_q[QW-1][0]);
    h_up    = (h_twice > {1'b0, it.delta}) ||
              ((h_twice == {1'b0, it.delta}) && hue_quo_q[QW-1][0]);
    sat     = sat_quo_q[QW-1] + {{(CW-1){1'b0}}, s_up};
    hq      = hue_quo_q[QW-1] + {{(CW-1){1'b0}}, h_up};
    unique case (it.sector)
      rhc_pkg::SectRed:   off = '0;
      rhc_pkg::SectGreen: off = rhc_pkg::HueGreenOff;
      rhc_pkg::SectBlue:  off = rhc_pkg::HueBlueOff;
      default:            off = '0;
    endcase
    if (!it.hue_neg) begin
      hue = off + hq;
    end else if (it.sector == rhc_pkg::SectRed) begin
      // negative red-sector hue wraps round the circle
      hue = (hq == '0) ? '0 : rhc_pkg::HueWrap - hq;
    end else begin
      hue = off - hq;
    end
    if (it.grey) begin
      hue = '0;
      sat = '0;
    end
    out_data_d = {it.value, sat, hue};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_valid_q  <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      st_valid_q  <= st_valid_d;
      out_valid_q <= st_valid_q[QW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < QW; k++) begin
        st_item_q[k] <= st_item_d[k];
        sat_rem_q[k] <= sat_rem_d[k];
        sat_quo_q[k] <= sat_quo_d[k];
        hue_rem_q[k] <= hue_rem_d[k];
        hue_quo_q[k] <= hue_quo_d[k];
      end
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

>>> rtl/rgb_to_hsv_pixel_converter.sv
// Top level of the 8-bit RGB to HSV pixel converter.
`timescale 1ns / 1ps
// A pixel passes the front register, the queue, the 8-stage divider pipeline and the output register.
// Throughput: one pixel per cycle while the output does not stall (one quotient bit a divider stage).
// The queue between front and back end holds FifoDepth pixels, so a short output
// stall does not stop the input side at once.
// Reset (rst_ni, async, active low) empties the front register, queue and pipeline.

module rgb_to_hsv_pixel_converter #(
  parameter int unsigned FifoDepth = rhc_pkg::FifoDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // pixel input
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // [7:0] blue, [15:8] green, [23:16] red
  // HSV output
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o    // [7:0] hue, [15:8] saturation, [23:16] value
);

  // Front end: max/min, sector choice, numerators 255*delta and 30*|diff|
  rhc_pkg::item_t front_item, fifo_item;
  logic           front_valid, fifo_full, fifo_empty, fifo_pop;

  rhc_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .item_valid_o    (front_valid),
    .item_ready_i    (!fifo_full),
    .item_o          (front_item)
  );

  // Queue decouples the two halves so each can stall on its own
  rhc_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_valid),
    .item_i  (front_item),
    .full_o  (fifo_full),
    .pop_i   (fifo_pop),
    .empty_o (fifo_empty),
    .item_o  (fifo_item)
  );

  // Back end: both divisions side by side, rounding, hue offset, output register
  rhc_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .item_empty_i    (fifo_empty),
    .item_i          (fifo_item),
    .item_pop_o      (fifo_pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

endmodule

>>> rtl/rhc_checker.sv
// Port-level checks on the RGB to HSV converter, bound to the top level.
`timescale 1ns / 1ps

module rhc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [23:0] m_axis_tdata_o
);

  // A result waiting for the sink stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("output valid dropped while stalled");

  // A result waiting for the sink keeps its data
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("output data changed while stalled");

  // Hue only covers 0..179
  a_hue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[7:0] < 8'd180))
    else $error("hue out of range");

  // Zero saturation only for grey pixels, which carry zero hue
  a_grey_hue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tdata_o[15:8] == 8'd0) |-> (m_axis_tdata_o[7:0] == 8'd0))
    else $error("non-zero hue with zero saturation");

  // Saturation never exceeds what value allows: black gives zero saturation
  a_black_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tdata_o[23:16] == 8'd0) |-> (m_axis_tdata_o[15:8] == 8'd0))
    else $error("non-zero saturation for black pixel");

endmodule

bind rgb_to_hsv_pixel_converter rhc_checker u_rhc_checker (.*);

>>> tb/rgb_to_hsv_pixel_converter_tb.sv
// Self-checking testbench for the 8-bit RGB to HSV pixel converter.
`timescale 1ns / 1ps

module rgb_to_hsv_pixel_converter_tb;

  localparam int unsigned NumRandom   = 1100;
  localparam int unsigned IdleLimit   = 2000;  // cycles without any transfer
  localparam int unsigned DrainCycles = 30;    // leave room for stray results
  localparam int unsigned NumDirected = 24;

  typedef struct packed {
    logic [rhc_pkg::ChanW-1:0] hue;
    logic [rhc_pkg::ChanW-1:0] saturation;
    logic [rhc_pkg::ChanW-1:0] value;
  } hsv_t;

  // One directed pixel; where known_res is set the result is typed in here
  typedef struct packed {
    logic [rhc_pkg::ChanW-1:0] blue;
    logic [rhc_pkg::ChanW-1:0] green;
    logic [rhc_pkg::ChanW-1:0] red;
    logic                      known_res;
    hsv_t                      res;
  } pixel_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [23:0] s_axis_tdata_i;   // [7:0] blue, [15:8] green, [23:16] red
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [23:0] m_axis_tdata_o;   // [7:0] hue, [15:8] saturation, [23:16] value

  // Typed-in result travelling alongside the pixel being offered
  logic        offer_known;
  hsv_t        offer_res;

  hsv_t        pending_hsv[$];
  int unsigned err_count;
  int unsigned pixels_in;
  int unsigned results_out;
  int unsigned grey_seen;
  int unsigned wrapped_seen;
  int unsigned sector_seen[3];
  int unsigned idle_cycles;

  pixel_row_t directed_rows [NumDirected] = '{
    // extremes and grey pixels
    '{8'd0,   8'd0,   8'd0,   1'b1, '{8'd0,   8'd0,   8'd0}},
    '{8'd255, 8'd255, 8'd255, 1'b1, '{8'd0,   8'd0,   8'd255}},
    '{8'd128, 8'd128, 8'd128, 1'b1, '{8'd0,   8'd0,   8'd128}},
    '{8'd1,   8'd1,   8'd1,   1'b1, '{8'd0,   8'd0,   8'd1}},
    // primaries, one per sector
    '{8'd0,   8'd0,   8'd255, 1'b1, '{8'd0,   8'd255, 8'd255}},
    '{8'd0,   8'd255, 8'd0,   1'b1, '{8'd60,  8'd255, 8'd255}},
    '{8'd255, 8'd0,   8'd0,   1'b1, '{8'd120, 8'd255, 8'd255}},
    // ties at the maximum: red beats green, green beats blue, red beats blue (wraps)
    '{8'd0,   8'd255, 8'd255, 1'b1, '{8'd30,  8'd255, 8'd255}},
    '{8'd255, 8'd255, 8'd0,   1'b1, '{8'd90,  8'd255, 8'd255}},
    '{8'd255, 8'd0,   8'd255, 1'b1, '{8'd150, 8'd255, 8'd255}},
    // smallest non-grey delta, red/blue tie with a step below
    '{8'd0,   8'd0,   8'd1,   1'b0, '0},
    '{8'd255, 8'd254, 8'd255, 1'b0, '0},
    // hue rounding on an exact half: negative, up to even, down to even
    '{8'd1,   8'd0,   8'd4,   1'b0, '0},
    '{8'd0,   8'd1,   8'd4,   1'b0, '0},
    '{8'd0,   8'd3,   8'd4,   1'b0, '0},
    // saturation rounding on an exact half
    '{8'd1,   8'd1,   8'd2,   1'b0, '0},
    '{8'd5,   8'd5,   8'd6,   1'b0, '0},
    // negative parts inside the green and blue sectors, positive in blue
    '{8'd0,   8'd255, 8'd128, 1'b0, '0},
    '{8'd255, 8'd128, 8'd0,   1'b0, '0},
    '{8'd200, 8'd0,   8'd100, 1'b0, '0},
    // small negative red part rounding to zero, and to the top hue
    '{8'd1,   8'd0,   8'd255, 1'b0, '0},
    '{8'd5,   8'd0,   8'd255, 1'b0, '0},
    // alternating bit patterns
    '{8'hAA,  8'h55,  8'hAA,  1'b0, '0},
    '{8'h55,  8'hAA,  8'h55,  1'b0, '0}
  };

  rgb_to_hsv_pixel_converter dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // round(num/den), exact half goes to the even neighbour; den > 0
  function automatic int unsigned div_round_even(int unsigned num, int unsigned den);
    int unsigned quo;
    int unsigned rem;
    quo = num / den;
    rem = num % den;
    if (2 * rem > den || (2 * rem == den && quo[0])) quo++;
    return quo;
  endfunction

  // signed hue step within a sector, |diff| <= delta
  function automatic int hue_step(int diff, int unsigned delta);
    if (diff >= 0) return int'(div_round_even(30 * diff, delta));
    return -int'(div_round_even(30 * (-diff), delta));
  endfunction

  function automatic rhc_pkg::sector_e sector_of(logic [7:0] b, logic [7:0] g,
                                                 logic [7:0] r);
    if (r >= g && r >= b) return rhc_pkg::SectRed;
    if (g >= b) return rhc_pkg::SectGreen;
    return rhc_pkg::SectBlue;
  endfunction

  function automatic hsv_t pixel_to_hsv(logic [7:0] b, logic [7:0] g, logic [7:0] r);
    hsv_t        res;
    int          hue;
    int unsigned hi;
    int unsigned lo;
    int unsigned delta;
    hi    = (r > g) ? r : g;
    hi    = (b > hi) ? b : hi;
    lo    = (r < g) ? r : g;
    lo    = (b < lo) ? b : lo;
    delta = hi - lo;
    hue   = 0;
    res.saturation = '0;
    if (delta != 0) begin
      res.saturation = 8'(div_round_even(255 * delta, hi));
      case (sector_of(b, g, r))
        rhc_pkg::SectRed:   hue = hue_step(int'(g) - int'(b), delta);
        rhc_pkg::SectGreen: hue = int'(rhc_pkg::HueGreenOff) +
                                  hue_step(int'(b) - int'(r), delta);
        default:            hue = int'(rhc_pkg::HueBlueOff) +
                                  hue_step(int'(r) - int'(g), delta);
      endcase
      if (hue < 0) hue += int'(rhc_pkg::HueWrap);
    end
    res.hue   = 8'(hue);
    res.value = 8'(hi);
    return res;
  endfunction

  // Random pixel, shaped to hit grey, ties at the maximum and rounding halves often
  function automatic logic [23:0] random_pixel();
    logic [7:0]  ch[3];
    int unsigned kind;
    int unsigned hi;
    int unsigned lo;
    int unsigned spread;
    int unsigned pick;
    kind = $urandom_range(0, 99);
    for (int i = 0; i < 3; i++) ch[i] = 8'($urandom_range(0, 255));
    if (kind < 5) begin
      ch[1] = ch[0];
      ch[2] = ch[0];
    end else if (kind < 20) begin
      // two channels share the maximum
      hi   = $urandom_range(1, 255);
      pick = $urandom_range(0, 2);
      for (int i = 0; i < 3; i++) ch[i] = 8'(hi);
      ch[pick] = 8'($urandom_range(0, hi - 1));
    end else if (kind < 35) begin
      for (int i = 0; i < 3; i++) ch[i] = 8'($urandom_range(0, 7));
    end else if (kind < 45) begin
      for (int i = 0; i < 3; i++) begin
        pick  = $urandom_range(0, 3);
        ch[i] = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd1 : (pick == 2) ? 8'd254 : 8'd255;
      end
    end else if (kind < 60) begin
      // nearly grey, delta of at most three counts anywhere in range
      spread = $urandom_range(1, 3);
      lo     = $urandom_range(0, 255 - spread);
      for (int i = 0; i < 3; i++) ch[i] = 8'(lo + $urandom_range(0, spread));
    end
    return {ch[2], ch[1], ch[0]};
  endfunction

  // Offer one pixel from a falling edge and return at the falling edge after its transfer
  task automatic offer_pixel(logic [23:0] pix, logic known, hsv_t res);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= pix;
    offer_known     <= known;
    offer_res       <= res;
    do @(posedge clk_i); while (!s_axis_tready_o);
    @(negedge clk_i);
  endtask

  // Input side: every transfer queues the result it must produce
  always @(posedge clk_i) begin
    hsv_t             res;
    rhc_pkg::sector_e sect;
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o) begin
      res  = pixel_to_hsv(s_axis_tdata_i[7:0], s_axis_tdata_i[15:8], s_axis_tdata_i[23:16]);
      sect = sector_of(s_axis_tdata_i[7:0], s_axis_tdata_i[15:8], s_axis_tdata_i[23:16]);
      pending_hsv.push_back(offer_known ? offer_res : res);
      pixels_in++;
      if (res.saturation == 0 && res.value == 0 || res.value == s_axis_tdata_i[7:0] &&
          res.value == s_axis_tdata_i[15:8] && res.value == s_axis_tdata_i[23:16])
        grey_seen++;
      else begin
        sector_seen[sect]++;
        if (res.hue > rhc_pkg::HueBlueOff + 8'd30) wrapped_seen++;
      end
    end
  end

  // Output side: compare each result transfer with the oldest pending result
  always @(posedge clk_i) begin
    hsv_t want;
    hsv_t got;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = '{m_axis_tdata_o[7:0], m_axis_tdata_o[15:8], m_axis_tdata_o[23:16]};
      results_out++;
      if (pending_hsv.size() == 0) begin
        err_count++;
        $display("%0t: unexpected result h=%0d s=%0d v=%0d", $time,
                 got.hue, got.saturation, got.value);
      end else begin
        want = pending_hsv.pop_front();
        if (got.hue != want.hue) begin
          err_count++;
          $display("%0t: hue mismatch, expected %0d, actual %0d", $time, want.hue, got.hue);
        end
        if (got.saturation != want.saturation) begin
          err_count++;
          $display("%0t: saturation mismatch, expected %0d, actual %0d", $time,
                   want.saturation, got.saturation);
        end
        if (got.value != want.value) begin
          err_count++;
          $display("%0t: value mismatch, expected %0d, actual %0d", $time,
                   want.value, got.value);
        end
      end
    end
  end

  // Watchdog: too long without a transfer on either side ends the run
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("%0t: no transfer for %0d cycles, %0d results outstanding", $time,
               IdleLimit, pending_hsv.size());
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: segments of always-ready, coin-flip ready and alternating ready and stall runs
  always @(negedge clk_i) begin
    int unsigned seg_left;
    int unsigned mode;
    int unsigned run_left;
    if (seg_left == 0) begin
      seg_left = $urandom_range(20, 200);
      mode     = $urandom_range(0, 2);
      run_left = 0;
    end
    seg_left--;
    case (mode)
      0: m_axis_tready_i <= 1'b1;
      1: m_axis_tready_i <= 1'($urandom_range(0, 1));
      default: begin
        if (run_left == 0) begin
          run_left = $urandom_range(1, 20);
          m_axis_tready_i <= ~m_axis_tready_i;
        end
        run_left--;
      end
    endcase
  end

  initial begin
    int unsigned burst_left;
    int unsigned drain;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    m_axis_tready_i = 1'b0;
    offer_known     = 1'b0;
    offer_res       = '0;
    err_count       = 0;
    pixels_in       = 0;
    results_out     = 0;
    grey_seen       = 0;
    wrapped_seen    = 0;
    idle_cycles     = 0;
    sector_seen     = '{0, 0, 0};
    rst_ni          = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed pixels, back to back
    for (int i = 0; i < NumDirected; i++) begin
      offer_pixel({directed_rows[i].red, directed_rows[i].green, directed_rows[i].blue},
                  directed_rows[i].known_res, directed_rows[i].res);
    end

    // Random pixels in bursts; a quarter of the bursts are followed by no gap at all
    burst_left = 0;
    for (int i = 0; i < NumRandom; i++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        if ($urandom_range(0, 3) != 0) begin
          s_axis_tvalid_i <= 1'b0;
          repeat ($urandom_range(1, 12)) @(negedge clk_i);
        end
      end
      burst_left--;
      offer_pixel(random_pixel(), 1'b0, '0);
    end
    s_axis_tvalid_i <= 1'b0;

    // Wait for the pipeline to empty, then watch a while for stray results
    while (pending_hsv.size() != 0) @(posedge clk_i);
    for (drain = 0; drain < DrainCycles; drain++) @(posedge clk_i);

    $display("Pixels sent %0d, results checked %0d: grey %0d, red %0d, green %0d, blue %0d",
             pixels_in, results_out, grey_seen, sector_seen[rhc_pkg::SectRed],
             sector_seen[rhc_pkg::SectGreen], sector_seen[rhc_pkg::SectBlue]);
    $display("Red-sector hues wrapped past zero: %0d, mismatches: %0d",
             wrapped_seen, err_count);
    if (err_count == 0 && pending_hsv.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/rhc_pkg.sv
rtl/rhc_front.sv
rtl/rhc_fifo.sv
rtl/rhc_back.sv
rtl/rgb_to_hsv_pixel_converter.sv
rtl/rhc_checker.sv
tb/rgb_to_hsv_pixel_converter_tb.sv
